### rtl/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types and constants for the sparse triplet table.
// ----------------------------------------------------------------------------
package stt_pkg;

   // table geometry
   localparam int MAX_DIM     = 16;
   localparam int MAX_ENTRIES = 32;

   // field widths
   localparam int DIM_W   = 5;                          // matrix_dim register
   localparam int VAL_W   = 32;                         // element / key value
   localparam int IDX_W   = 4;                          // stored row / column
   localparam int POS_W   = $clog2(MAX_DIM + 1);        // row position, may reach dim
   localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);    // stored triplet count
   localparam int ADDR_W  = $clog2(MAX_ENTRIES);        // table address

   localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(5);

   // request codes
   localparam logic REQ_LOAD   = 1'b0;
   localparam logic REQ_SEARCH = 1'b1;

   // one stored triplet
   typedef struct packed {
      logic [VAL_W-1:0] value;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
   } triplet_type;

   localparam int TRIPLET_W = $bits(triplet_type);

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SCAN,
      ST_EMIT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;   // take the accepted item
      logic load;      // apply a load element
      logic scan;      // one step of the search scan
      logic emit;      // move the result into the output register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_done; // search finished (hit or end of table)
      logic out_free;  // output register can take a result
   } status_type;

endpackage

### rtl/stt_ram.sv
// ----------------------------------------------------------------------------
// stt_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module stt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/stt_ctrl.sv
// ----------------------------------------------------------------------------
// stt_ctrl
// Sequencer for the sparse triplet table: accepts one item, runs the load
// update or the search scan, then hands the result to the output register.
// ----------------------------------------------------------------------------
module stt_ctrl
   import stt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_type,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_type == REQ_SEARCH) ? ST_SCAN : ST_LOAD;
            end
         end
         ST_LOAD: begin
            state_in = ST_EMIT;
         end
         ST_SCAN: begin
            if (status.scan_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
         end
         ST_EMIT: begin
            cmd.emit = status.out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

### rtl/stt_dp.sv
// ----------------------------------------------------------------------------
// stt_dp
// Datapath for the sparse triplet table: position counters, triplet RAM,
// pipelined search compare and the output register.
// ----------------------------------------------------------------------------
module stt_dp
   import stt_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   output status_type              status,
   input  logic                    csr_wr_en,
   input  logic [DIM_W-1:0]        csr_wr_data,
   input  logic                    req_start_matrix,
   input  logic signed [VAL_W-1:0] req_elem_value,
   input  logic signed [VAL_W-1:0] req_search_value,
   input  logic                    rsp_stall,
   output logic                    rsp_valid,
   output logic                    rsp_found,
   output logic [IDX_W-1:0]        rsp_match_row,
   output logic [IDX_W-1:0]        rsp_match_col,
   output logic [CNT_W-1:0]        rsp_entry_count,
   output logic                    rsp_overflow
);

   // configuration
   logic [DIM_W-1:0] dim_ff;

   // matrix state
   logic [CNT_W-1:0] count_ff, count_in;
   logic [POS_W-1:0] row_ff, row_in;
   logic [IDX_W-1:0] col_ff, col_in;
   logic             drop_ff, drop_in;

   // captured item
   logic             start_ff;
   logic [VAL_W-1:0] elem_ff;
   logic [VAL_W-1:0] key_ff;

   // scan state
   logic [CNT_W-1:0] addr_ff, addr_in;
   logic             pend_ff, pend_in;
   logic             found_ff;
   logic [IDX_W-1:0] mrow_ff;
   logic [IDX_W-1:0] mcol_ff;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_found_ff;
   logic [IDX_W-1:0] rsp_row_ff;
   logic [IDX_W-1:0] rsp_col_ff;
   logic [CNT_W-1:0] rsp_count_ff;
   logic             rsp_drop_ff;

   // ram ports
   logic              wr_en;
   triplet_type       wr_data;
   logic              rd_en;
   logic [TRIPLET_W-1:0] rd_raw;
   triplet_type       rd_data;

   // load helpers
   logic [DIM_W-1:0] dim_eff;
   logic [CNT_W-1:0] count_base;
   logic [POS_W-1:0] row_base;
   logic [IDX_W-1:0] col_base;
   logic             drop_base;
   logic [POS_W-1:0] col_next;

   // scan helpers
   logic issue;
   logic hit;
   logic scan_done;

   // dimension register
   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff <= DIM_RESET;
      end else if (csr_wr_en) begin
         dim_ff <= csr_wr_data;
      end
   end

   // clamp the dimension to 1..MAX_DIM
   always_comb begin
      dim_eff = dim_ff;
      if (dim_ff == '0) begin
         dim_eff = DIM_W'(1);
      end else if (dim_ff > DIM_W'(MAX_DIM)) begin
         dim_eff = DIM_W'(MAX_DIM);
      end
   end

   // item capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         start_ff <= req_start_matrix;
         elem_ff  <= req_elem_value;
         key_ff   <= req_search_value;
      end
   end

   // load update: start clears first, then the element is placed
   always_comb begin
      count_base = start_ff ? '0 : count_ff;
      row_base   = start_ff ? '0 : row_ff;
      col_base   = start_ff ? '0 : col_ff;
      drop_base  = start_ff ? 1'b0 : drop_ff;
      col_next   = POS_W'(col_base) + POS_W'(1);

      count_in = count_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      drop_in  = drop_ff;
      wr_en    = 1'b0;
      wr_data.value = elem_ff;
      wr_data.row   = row_base[IDX_W-1:0];
      wr_data.col   = col_base;

      if (cmd.load) begin
         count_in = count_base;
         row_in   = row_base;
         col_in   = col_base;
         drop_in  = drop_base;
         if (row_base < POS_W'(dim_eff)) begin
            if (elem_ff != '0) begin
               if (count_base < CNT_W'(MAX_ENTRIES)) begin
                  wr_en    = 1'b1;
                  count_in = count_base + CNT_W'(1);
               end else begin
                  drop_in = 1'b1;
               end
            end
            if (col_next >= POS_W'(dim_eff)) begin
               col_in = '0;
               row_in = row_base + POS_W'(1);
            end else begin
               col_in = col_next[IDX_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         row_ff   <= '0;
         col_ff   <= '0;
         drop_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         drop_ff  <= drop_in;
      end
   end

   // triplet storage
   stt_ram #(
      .WIDTH (TRIPLET_W),
      .DEPTH (MAX_ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_base[ADDR_W-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (addr_ff[ADDR_W-1:0]),
      .rd_data (rd_raw)
   );

   assign rd_data = triplet_type'(rd_raw);

   // scan: read one entry per cycle, compare the one read last cycle
   always_comb begin
      hit     = cmd.scan && pend_ff && (rd_data.value == key_ff);
      issue   = addr_ff < count_ff;
      rd_en   = cmd.scan && issue && !hit;
      addr_in = addr_ff;
      pend_in = 1'b0;
      if (cmd.capture) begin
         addr_in = '0;
      end else if (rd_en) begin
         addr_in = addr_ff + CNT_W'(1);
         pend_in = 1'b1;
      end
      scan_done = hit || (!pend_ff && !issue);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
   end

   // match result, cleared on every new item
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         found_ff <= 1'b0;
         mrow_ff  <= '0;
         mcol_ff  <= '0;
      end else if (hit) begin
         found_ff <= 1'b1;
         mrow_ff  <= rd_data.row;
         mcol_ff  <= rd_data.col;
      end
   end

   // status to the controller
   assign status.scan_done = scan_done;
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_found_ff <= found_ff;
         rsp_row_ff   <= mrow_ff;
         rsp_col_ff   <= mcol_ff;
         rsp_count_ff <= count_ff;
         rsp_drop_ff  <= drop_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_match_row   = rsp_row_ff;
   assign rsp_match_col   = rsp_col_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_overflow    = rsp_drop_ff;

endmodule

### rtl/sparse_triplet_table.sv
// A load item passes through the load state and the emit state before its result
// enters the output register. A search scans the stored triplets, reading and
// comparing one entry per cycle over the triplet RAM, until the first match or
// the end of the table. One item is handled at a time; the next item is accepted
// the cycle after the previous result enters the output register. Reset
// (synchronous, active high) empties the table and sets dim 5.
// ----------------------------------------------------------------------------
// sparse_triplet_table
// Stores the nonzero elements of a square matrix as (row, column, value)
// triplets and looks up the first triplet holding a given value.
// ----------------------------------------------------------------------------
module sparse_triplet_table
   import stt_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   // configuration
   input  logic                    csr_wr_en,
   input  logic [DIM_W-1:0]        csr_wr_data,
   // request channel
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_type,
   input  logic                    req_start_matrix,
   input  logic signed [VAL_W-1:0] req_elem_value,
   input  logic signed [VAL_W-1:0] req_search_value,
   // response channel
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_found,
   output logic [IDX_W-1:0]        rsp_match_row,
   output logic [IDX_W-1:0]        rsp_match_col,
   output logic [CNT_W-1:0]        rsp_entry_count,
   output logic                    rsp_overflow
);

   cmd_type    cmd;
   status_type status;

   // sequencer
   stt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // counters, table and output register
   stt_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_start_matrix (req_start_matrix),
      .req_elem_value   (req_elem_value),
      .req_search_value (req_search_value),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_found        (rsp_found),
      .rsp_match_row    (rsp_match_row),
      .rsp_match_col    (rsp_match_col),
      .rsp_entry_count  (rsp_entry_count),
      .rsp_overflow     (rsp_overflow)
   );

endmodule
